/* hdl/inhx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inhx_pkg
// Shared types and constants for the INHX16 record parser: parse phases,
// error codes, record types and the structs passed between modules.
// ----------------------------------------------------------------------------
package inhx_pkg;

  localparam int AddrWidth = 21;
  localparam int WordWidth = 16;

  // record type bytes
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;

  // segment record must carry this word count
  localparam logic [7:0] SEG_WORDS = 8'h02;

  // hex digits per field
  localparam logic [2:0] DIGITS_BYTE = 3'd2;
  localparam logic [2:0] DIGITS_WORD = 3'd4;

  // characters of interest
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SEGMENT  = 3'd1,
    ERR_TYPE     = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_CORRUPT  = 3'd4
  } error_t;

  typedef enum logic [7:0] {
    PH_COLON = 8'b0000_0001,
    PH_COUNT = 8'b0000_0010,
    PH_ADDR  = 8'b0000_0100,
    PH_TYPE  = 8'b0000_1000,
    PH_SEG   = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CKSUM = 8'b0100_0000,
    PH_SKIP  = 8'b1000_0000
  } phase_t;

  // character classification
  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
    logic       is_colon;
    logic       is_lf;
  } char_class_t;

  // per-transaction result
  typedef struct packed {
    logic                 write_valid;
    logic [AddrWidth-1:0] write_address;
    logic [WordWidth-1:0] write_data;
    logic                 finished;
    error_t               error_code;
  } result_t;

endpackage

/* hdl/inhx_char_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inhx_char_decode
// Classifies one ASCII character: hex digit value, colon, line feed.
// ----------------------------------------------------------------------------
module inhx_char_decode
  import inhx_pkg::*;
(
  input  logic [7:0]  char_code,
  output char_class_t char_class
);

  // hex digit lookup over the three digit ranges
  always_comb begin
    char_class.is_hex   = 1'b0;
    char_class.digit    = 4'd0;
    char_class.is_colon = (char_code == CHAR_COLON);
    char_class.is_lf    = (char_code == CHAR_LF);
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      char_class.is_hex = 1'b1;
      char_class.digit  = char_code[3:0];
    end else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                 (char_code >= 8'h61 && char_code <= 8'h66)) begin
      char_class.is_hex = 1'b1;
      char_class.digit  = 4'(char_code[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

/* hdl/inhx_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inhx_parse_core
// Line parser state and its next-state logic. Works out the result of the
// current character in one pass and updates the state on each transaction.
// ----------------------------------------------------------------------------
module inhx_parse_core
  import inhx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  char_class_t char_class,
  input  logic        end_of_input,
  output result_t     result,
  output logic        done_flag,
  output error_t      error_held
);

  phase_t         parse_phase, parse_phase_next;
  logic [2:0]     digit_count, digit_count_next;
  logic [7:0]     word_count, word_count_next;
  logic [15:0]    record_address, record_address_next;
  logic [7:0]     running_sum, running_sum_next;
  logic [15:0]    segment_base, segment_base_next;
  logic [7:0]     word_offset, word_offset_next;
  logic [15:0]    hex_accumulator, hex_accumulator_next;
  logic           done_flag_next;
  error_t         error_held_next;

  logic [15:0]    acc_shifted;
  logic [2:0]     digit_inc;
  logic [2:0]     digits_needed;
  logic           field_done;
  logic [7:0]     word_sum;
  logic [7:0]     offset_inc;
  logic [AddrWidth-1:0] address_sum;

  // field assembly
  assign acc_shifted   = {hex_accumulator[11:0], char_class.digit};
  assign digit_inc     = digit_count + 3'd1;
  assign digits_needed = (parse_phase == PH_ADDR || parse_phase == PH_SEG ||
                          parse_phase == PH_DATA) ? DIGITS_WORD : DIGITS_BYTE;
  assign field_done    = (digit_inc >= digits_needed);
  assign word_sum      = running_sum + acc_shifted[15:8] + acc_shifted[7:0];
  assign offset_inc    = word_offset + 8'd1;
  assign address_sum   = {1'b0, segment_base, 4'd0} + AddrWidth'(record_address) +
                         AddrWidth'(word_offset);

  // next state and result of the current character
  always_comb begin
    parse_phase_next     = parse_phase;
    digit_count_next     = digit_count;
    word_count_next      = word_count;
    record_address_next  = record_address;
    running_sum_next     = running_sum;
    segment_base_next    = segment_base;
    word_offset_next     = word_offset;
    hex_accumulator_next = hex_accumulator;
    done_flag_next       = done_flag;
    error_held_next      = error_held;
    result.write_valid   = 1'b0;
    result.write_address = '0;
    result.write_data    = '0;

    if (!done_flag && error_held == ERR_NONE) begin
      if (end_of_input) begin
        error_held_next = ERR_CORRUPT;
      end else if (parse_phase == PH_COLON) begin
        if (char_class.is_colon) begin
          parse_phase_next     = PH_COUNT;
          digit_count_next     = 3'd0;
          hex_accumulator_next = 16'd0;
          running_sum_next     = 8'd0;
          word_offset_next     = 8'd0;
        end else begin
          error_held_next = ERR_CORRUPT;
        end
      end else if (parse_phase == PH_SKIP) begin
        if (char_class.is_lf) begin
          parse_phase_next = PH_COLON;
        end
      end else if (!char_class.is_hex) begin
        error_held_next = ERR_CORRUPT;
      end else if (!field_done) begin
        hex_accumulator_next = acc_shifted;
        digit_count_next     = digit_inc;
      end else begin
        hex_accumulator_next = 16'd0;
        digit_count_next     = 3'd0;
        // act on the completed field
        case (parse_phase)
          PH_COUNT: begin
            word_count_next  = acc_shifted[7:0];
            running_sum_next = running_sum + acc_shifted[7:0];
            parse_phase_next = PH_ADDR;
          end
          PH_ADDR: begin
            record_address_next = acc_shifted;
            running_sum_next    = word_sum;
            parse_phase_next    = PH_TYPE;
          end
          PH_TYPE: begin
            running_sum_next = running_sum + acc_shifted[7:0];
            if (acc_shifted[7:0] == REC_EOF) begin
              done_flag_next = 1'b1;
            end else if (acc_shifted[7:0] == REC_SEGMENT) begin
              if (word_count != SEG_WORDS || record_address != 16'd0) begin
                error_held_next = ERR_SEGMENT;
              end else begin
                parse_phase_next = PH_SEG;
              end
            end else if (acc_shifted[7:0] == REC_DATA) begin
              parse_phase_next = (word_count == 8'd0) ? PH_CKSUM : PH_DATA;
            end else begin
              error_held_next = ERR_TYPE;
            end
          end
          PH_SEG: begin
            segment_base_next = acc_shifted;
            running_sum_next  = word_sum;
            parse_phase_next  = PH_CKSUM;
          end
          PH_DATA: begin
            result.write_valid   = 1'b1;
            result.write_address = address_sum;
            result.write_data    = acc_shifted;
            running_sum_next     = word_sum;
            word_offset_next     = offset_inc;
            if (offset_inc == word_count) begin
              parse_phase_next = PH_CKSUM;
            end
          end
          PH_CKSUM: begin
            if (8'(8'd0 - running_sum) != acc_shifted[7:0]) begin
              error_held_next = ERR_CHECKSUM;
            end else begin
              parse_phase_next = PH_SKIP;
            end
          end
          default: begin
            parse_phase_next = PH_COLON;
          end
        endcase
      end
    end

    result.finished   = done_flag_next;
    result.error_code = error_held_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_COLON;
      done_flag   <= 1'b0;
      error_held  <= ERR_NONE;
    end else if (accept) begin
      parse_phase <= parse_phase_next;
      done_flag   <= done_flag_next;
      error_held  <= error_held_next;
    end
  end

  // line registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count     <= 3'd0;
      word_count      <= 8'd0;
      record_address  <= 16'd0;
      running_sum     <= 8'd0;
      segment_base    <= 16'd0;
      word_offset     <= 8'd0;
      hex_accumulator <= 16'd0;
    end else if (accept) begin
      digit_count     <= digit_count_next;
      word_count      <= word_count_next;
      record_address  <= record_address_next;
      running_sum     <= running_sum_next;
      segment_base    <= segment_base_next;
      word_offset     <= word_offset_next;
      hex_accumulator <= hex_accumulator_next;
    end
  end

endmodule

/* hdl/inhx16_record_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inhx16_record_parser_top
// INHX16 hex text parser: one character in, one result out per transaction.
// ----------------------------------------------------------------------------
// Takes one character of 16-bit-word Intel HEX text per transaction and
// returns one result per character: a word write (segment base times 16 plus
// record address plus word index) when the character completes a data word,
// plus the sticky finished flag and error code. One character is accepted
// every clock cycle unless the input is stalled; the parse state and the output
// register both load at the edge that accepts a character, so its result is
// offered from the next cycle on. Input is stalled only while that output
// register is full and stalled. Once an end record or an error is seen the
// parser ignores further input.
module inhx16_record_parser_top
  import inhx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_code,
  input  logic                 end_of_input,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 write_valid,
  output logic [AddrWidth-1:0] write_address,
  output logic [WordWidth-1:0] write_data,
  output logic                 finished,
  output logic [2:0]           error_code
);

  char_class_t char_class;
  result_t     result;
  result_t     result_reg;
  logic        accept;
  logic        done_flag;
  error_t      error_held;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // character classification
  inhx_char_decode u_decode (
    .char_code  (char_code),
    .char_class (char_class)
  );

  // parse state and next-state logic
  inhx_parse_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_class   (char_class),
    .end_of_input (end_of_input),
    .result       (result),
    .done_flag    (done_flag),
    .error_held   (error_held)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result_reg <= result;
    end
  end

  assign write_valid   = result_reg.write_valid;
  assign write_address = result_reg.write_address;
  assign write_data    = result_reg.write_data;
  assign finished      = result_reg.finished;
  assign error_code    = result_reg.error_code;

`ifndef ASSERT_OFF
  // an error code never changes once set
  assert property (@(posedge clk) disable iff (rst)
    error_held != ERR_NONE |=> error_held == $past(error_held))
    else $error("error code changed after being set");

  // finished and error are exclusive
  assert property (@(posedge clk) disable iff (rst)
    !(done_flag && error_held != ERR_NONE))
    else $error("finished and error both set");

  // a write is only reported while the parser is still running
  assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> !finished && error_code == ERR_NONE)
    else $error("write reported with finished or error");
`endif

endmodule
